>>> src/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types, constants and saturation helper for the biquad section.
// ----------------------------------------------------------------------------
package biq_pkg;

    // Width of the internal accumulator and of both delay state words
    localparam int ACC_WIDTH = 52;
    localparam int WIDE_WIDTH = 64;
    localparam int NUM_COEF = 5;
    localparam int COEF_IDX_WIDTH = 3;

    localparam logic signed [WIDE_WIDTH-1:0] ACC_MAX =
        (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
    localparam logic signed [WIDE_WIDTH-1:0] ACC_MIN = -ACC_MAX - 64'sd1;

    // Coefficient register indexes, also used to pick the multiplier operand
    typedef enum logic [COEF_IDX_WIDTH-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B0,
        ST_SUM,
        ST_RND,
        ST_A1,
        ST_SUB1,
        ST_ADD2,
        ST_SUB2
    } t_state;

    // Adder operation, each with a fixed destination
    typedef enum logic [2:0] {
        ADD_NONE,
        ADD_SUM,   // acc <= prod + s1
        ADD_FB1,   // acc <= acc - prod
        ADD_S1,    // s1  <= acc + s2
        ADD_S2     // s2  <= acc - prod
    } t_add_op;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        t_coef_idx mul_sel;
        t_add_op   add_op;
        logic      acc_load;
        logic      y_en;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Clamp a wide signed value to the accumulator range
    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
        input logic signed [WIDE_WIDTH-1:0] v
    );
        logic signed [ACC_WIDTH-1:0] r;
        if (v > ACC_MAX) begin
            r = ACC_MAX[ACC_WIDTH-1:0];
        end else if (v < ACC_MIN) begin
            r = ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            r = v[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/biq_coef_regs.sv
// ----------------------------------------------------------------------------
// biq_coef_regs
// Coefficient register file written through the configuration port.
// ----------------------------------------------------------------------------
module biq_coef_regs
    import biq_pkg::*;
#(
    parameter int COEF_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [COEF_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [COEF_WIDTH-1:0]        i_cfg_data,
    output logic signed [COEF_WIDTH-1:0] o_coef [NUM_COEF]
);

    localparam logic signed [COEF_WIDTH-1:0] UnityGain =
        COEF_WIDTH'(1) << (COEF_WIDTH - 3);

    logic signed [COEF_WIDTH-1:0] r_coef [NUM_COEF];
    logic                         wr_en;

    assign o_cfg_ready = 1'b1;
    assign wr_en       = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[COEF_B0] <= UnityGain;
            r_coef[COEF_B1] <= '0;
            r_coef[COEF_B2] <= '0;
            r_coef[COEF_A1] <= '0;
            r_coef[COEF_A2] <= '0;
        end else if (wr_en) begin
            // drop writes to unused indexes
            unique case (i_cfg_index)
                COEF_B0: r_coef[COEF_B0] <= i_cfg_data;
                COEF_B1: r_coef[COEF_B1] <= i_cfg_data;
                COEF_B2: r_coef[COEF_B2] <= i_cfg_data;
                COEF_A1: r_coef[COEF_A1] <= i_cfg_data;
                COEF_A2: r_coef[COEF_A2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

>>> src/biq_ctrl.sv
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer stepping one sample through the shared multiplier and adder.
// ----------------------------------------------------------------------------
module biq_ctrl
    import biq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_B0;
            ST_B0:   n_state = ST_SUM;
            ST_SUM:  n_state = ST_RND;
            ST_RND:  n_state = ST_A1;
            ST_A1:   n_state = ST_SUB1;
            ST_SUB1: n_state = ST_ADD2;
            ST_ADD2: n_state = ST_SUB2;
            ST_SUB2: if (i_status.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd.load     = 1'b0;
        o_cmd.mul_en   = 1'b0;
        o_cmd.mul_sel  = COEF_B0;
        o_cmd.add_op   = ADD_NONE;
        o_cmd.acc_load = 1'b0;
        o_cmd.y_en     = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_B0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = COEF_B0;
            end
            ST_SUM: begin
                o_cmd.add_op  = ADD_SUM;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = COEF_B1;
            end
            ST_RND: begin
                o_cmd.y_en     = 1'b1;
                o_cmd.acc_load = 1'b1;
            end
            ST_A1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = COEF_A1;
            end
            ST_SUB1: begin
                o_cmd.add_op  = ADD_FB1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = COEF_B2;
            end
            ST_ADD2: begin
                o_cmd.add_op   = ADD_S1;
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = COEF_A2;
            end
            ST_SUB2: begin
                // hold until the output register can take the request
                if (i_status.out_free) begin
                    o_cmd.add_op   = ADD_S2;
                    o_cmd.out_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded while output register busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_B0))
        else $error("accepted request did not start the sequence");

    a_stall_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_cmd.load))
        else $error("input stalled without an accepted request");

endmodule

>>> src/biq_datapath.sv
// ----------------------------------------------------------------------------
// biq_datapath
// Shared multiplier, saturating adder, rounding stage, state and output regs.
// ----------------------------------------------------------------------------
module biq_datapath
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_status                     o_status,
    input  logic signed [COEF_WIDTH-1:0]   i_coef [NUM_COEF],
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_clear_state,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_saturated
);

    localparam int FracBits  = COEF_WIDTH - 3;
    localparam int ProdWidth = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int RndWidth  = ACC_WIDTH + 1;
    localparam logic signed [RndWidth-1:0] RoundHalf = RndWidth'(1) << (FracBits - 1);
    localparam logic signed [RndWidth-1:0] SatHi =
        RndWidth'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RndWidth-1:0] SatLo = -SatHi - RndWidth'(1);

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_sat;
    logic signed [ACC_WIDTH-1:0]    r_prod;
    logic signed [ACC_WIDTH-1:0]    r_acc;
    logic signed [ACC_WIDTH-1:0]    r_s1;
    logic signed [ACC_WIDTH-1:0]    r_s2;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample_out;
    logic                           r_saturated;

    logic signed [COEF_WIDTH-1:0]   mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] mul_data;
    logic signed [ProdWidth-1:0]    mul_raw;
    logic signed [ACC_WIDTH-1:0]    n_prod;

    logic signed [ACC_WIDTH-1:0]    add_a;
    logic signed [ACC_WIDTH-1:0]    add_b;
    logic                           add_sub;
    logic signed [WIDE_WIDTH-1:0]   add_wide;
    logic signed [ACC_WIDTH-1:0]    add_res;

    logic signed [RndWidth-1:0]     rnd_sum;
    logic signed [RndWidth-1:0]     rnd_shift;
    logic signed [SAMPLE_WIDTH-1:0] n_y;
    logic                           n_sat;

    // Multiplier: feedback taps take the output sample, the rest the input
    assign mul_coef = i_coef[i_cmd.mul_sel];
    assign mul_data = (i_cmd.mul_sel == COEF_A1 || i_cmd.mul_sel == COEF_A2) ? r_y : r_x;
    assign mul_raw  = mul_coef * mul_data;
    assign n_prod   = sat_acc(WIDE_WIDTH'(mul_raw));

    // Saturating adder
    always_comb begin
        add_a   = r_acc;
        add_b   = r_prod;
        add_sub = 1'b0;
        unique case (i_cmd.add_op)
            ADD_SUM: begin
                add_a = r_prod;
                add_b = r_s1;
            end
            ADD_FB1: add_sub = 1'b1;
            ADD_S1:  add_b   = r_s2;
            ADD_S2:  add_sub = 1'b1;
            ADD_NONE: ;
            default: ;
        endcase
    end

    assign add_wide = add_sub ? (WIDE_WIDTH'(add_a) - WIDE_WIDTH'(add_b))
                              : (WIDE_WIDTH'(add_a) + WIDE_WIDTH'(add_b));
    assign add_res  = sat_acc(add_wide);

    // Round half up, then clamp to the sample range
    assign rnd_sum   = RndWidth'(r_acc) + RoundHalf;
    assign rnd_shift = rnd_sum >>> FracBits;

    always_comb begin
        n_sat = 1'b0;
        n_y   = rnd_shift[SAMPLE_WIDTH-1:0];
        if (rnd_shift > SatHi) begin
            n_y   = SatHi[SAMPLE_WIDTH-1:0];
            n_sat = 1'b1;
        end else if (rnd_shift < SatLo) begin
            n_y   = SatLo[SAMPLE_WIDTH-1:0];
            n_sat = 1'b1;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.add_op == ADD_SUM || i_cmd.add_op == ADD_FB1) begin
            r_acc <= add_res;
        end else if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end
        if (i_cmd.y_en) begin
            r_y   <= n_y;
            r_sat <= n_sat;
        end
        if (i_cmd.out_load) begin
            r_sample_out <= r_y;
            r_saturated  <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_clear_state) begin
                r_s1 <= '0;
                r_s2 <= '0;
            end else begin
                if (i_cmd.add_op == ADD_S1) begin
                    r_s1 <= add_res;
                end
                if (i_cmd.add_op == ADD_S2) begin
                    r_s2 <= add_res;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_sample_out == SatHi[SAMPLE_WIDTH-1:0] ||
             o_sample_out == SatLo[SAMPLE_WIDTH-1:0]))
        else $error("saturated flag set on an unclipped sample");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_clear_state) |=> (r_s1 == '0 && r_s2 == '0))
        else $error("state not cleared on request");

endmodule

>>> src/biquad_df2t_filter_top.sv
// An accepted input request steps through B0, SUM, RND, A1, SUB1, ADD2, SUB2,
// then its result is registered on the output. The five products and four sums
// of a sample run in turn through one shared multiplier and saturating adder.
// A result waiting on a stalled output holds the final step until it is taken;
// the next input is accepted as soon as the sequence has returned to idle.
// Reset (synchronous, active low) zeroes both state words and sets b0 to unity.
// ----------------------------------------------------------------------------
// biquad_df2t_filter_top
// Second-order IIR section, transposed direct form II, fixed point.
// ----------------------------------------------------------------------------
module biquad_df2t_filter_top
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [COEF_IDX_WIDTH-1:0]      i_cfg_index,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_clear_state,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_saturated
);

    logic signed [COEF_WIDTH-1:0] coef [NUM_COEF];
    t_dp_cmd                      dp_cmd;
    t_dp_status                   dp_status;

    biq_coef_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    biq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    biq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_coef        (coef),
        .i_sample_in   (i_sample_in),
        .i_clear_state (i_clear_state),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .o_saturated   (o_saturated)
    );

endmodule
